// ===== hdl/uets_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the USB endpoint transfer sequencer.
// No dependencies; imported by the sequencer core.
package uets_pkg;

    localparam int NUM_ENDPOINTS_DEF = 8;
    localparam int MAX_PACKET_DEF    = 64;
    localparam logic [6:0] EP0_PACKET = 7'd64;

    localparam logic [1:0] REQ_OPEN      = 2'd0;
    localparam logic [1:0] REQ_START     = 2'd1;
    localparam logic [1:0] REQ_TOKEN     = 2'd2;
    localparam logic [1:0] REQ_BUS_RESET = 2'd3;

    localparam logic [1:0] TOK_OUT   = 2'd0;
    localparam logic [1:0] TOK_SOF   = 2'd1;
    localparam logic [1:0] TOK_IN    = 2'd2;
    localparam logic [1:0] TOK_SETUP = 2'd3;

    localparam logic [1:0] RSP_NONE = 2'd0;
    localparam logic [1:0] RSP_ACK  = 2'd1;
    localparam logic [1:0] RSP_NACK = 2'd2;
    localparam logic [1:0] RSP_NYET = 2'd3;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_TOGGLE    = 2'd1;
    localparam logic [1:0] ERR_EP0_OUT   = 2'd2;
    localparam logic [1:0] ERR_EP0_MULTI = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [2:0]  endpoint;
        logic        dir_in;
        logic [6:0]  max_packet;
        logic [15:0] xfer_len;
        logic [1:0]  token_kind;
        logic        tog_ok;
        logic [6:0]  rx_len;
    } req_t;

    typedef struct packed {
        logic [1:0]  ep_response;
        logic        toggle_bit;
        logic [6:0]  load_len;
        logic [15:0] copy_offset;
        logic [6:0]  copy_len;
        logic        xfer_done;
        logic [15:0] done_count;
        logic        setup_seen;
        logic        reset_seen;
        logic [1:0]  error_code;
    } rsp_t;

    typedef struct packed {
        logic [15:0] total;
        logic [15:0] done_bytes;
        logic [6:0]  limit;
        logic [6:0]  in_flight;
    } entry_t;

endpackage

// ===== hdl/usb_endpoint_transfer_sequencer_core.sv =====
`timescale 1ns / 1ps
// USB endpoint transfer sequencer: per-endpoint transfer table and token handling.
// Depends on uets_pkg and uets_ram (endpoint table).
//
//  channel | valid      | stall      | payload
//  --------+------------+------------+--------------
//  request | req_valid  | req_stall  | req  (req_t)
//  result  | rsp_valid  | rsp_stall  | rsp  (rsp_t)
//
// Each request is handled in two steps: the endpoint table entry is read on accept,
// then it is modified and written back while the result register is loaded. The
// single table port pair sets these steps. One request is in flight at a time.
// Reset clears the active flags, restores the endpoint 0 packet limits to 64 and
// sets both endpoint 0 toggles; the table RAM itself is not cleared.
// A stalled result holds the result register and stalls the request side.
module usb_endpoint_transfer_sequencer_core
    import uets_pkg::*;
#(
    parameter int NUM_ENDPOINTS = NUM_ENDPOINTS_DEF,
    parameter int MAX_PACKET    = MAX_PACKET_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int SLOTS  = 2 * NUM_ENDPOINTS;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam logic [6:0] MAX_PKT = 7'(MAX_PACKET);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic              state_reg, state_next;
    req_t              cur_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOTS-1:0]  active_reg, active_next;
    logic [1:0]        dflt_reg, dflt_next;
    logic              in_tog_reg, in_tog_next;
    logic              out_tog_reg, out_tog_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;

    logic              accept;
    logic              acc_dir;
    logic [4:0]        acc_slot;
    logic [SLOT_W-1:0] acc_addr;
    logic [$bits(entry_t)-1:0] rd_raw;
    entry_t            rd;
    entry_t            ent_next;
    logic              ram_we;

    logic        cur_dir;
    logic        ep0;
    logic        in_range;
    logic [6:0]  eff_lim;
    logic [6:0]  mp;
    logic [6:0]  rx;
    logic [15:0] remain;
    logic [6:0]  n_out;
    logic [15:0] done_out;
    logic [15:0] done_in;
    logic [15:0] diff_in;
    logic [6:0]  n_in;
    logic [6:0]  n_start;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != ST_IDLE) || (rsp_valid_reg && rsp_stall);
    assign acc_dir   = (req.req_type == REQ_TOKEN) ? (req.token_kind == TOK_IN) : req.dir_in;
    assign acc_slot  = {1'b0, req.endpoint, acc_dir};
    assign acc_addr  = acc_slot[SLOT_W-1:0];

    uets_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (ent_next),
        .re    (accept),
        .raddr (acc_addr),
        .rdata (rd_raw)
    );

    assign rd       = entry_t'(rd_raw);
    assign cur_dir  = (cur_reg.req_type == REQ_TOKEN) ? (cur_reg.token_kind == TOK_IN)
                                                      : cur_reg.dir_in;
    assign ep0      = (cur_reg.endpoint == 3'd0);
    assign in_range = ({2'b00, cur_reg.endpoint} < 5'(NUM_ENDPOINTS));
    assign eff_lim  = (ep0 && dflt_reg[cur_dir]) ? EP0_PACKET : rd.limit;
    assign mp       = (cur_reg.max_packet > MAX_PKT) ? MAX_PKT : cur_reg.max_packet;
    assign rx       = (cur_reg.rx_len > MAX_PKT) ? MAX_PKT : cur_reg.rx_len;

    assign remain   = (rd.total > rd.done_bytes) ? (rd.total - rd.done_bytes) : 16'd0;
    assign n_out    = (remain < {9'd0, rx}) ? remain[6:0] : rx;
    assign done_out = rd.done_bytes + {9'd0, n_out};
    assign done_in  = rd.done_bytes + {9'd0, rd.in_flight};
    assign diff_in  = rd.total - done_in;
    assign n_in     = (diff_in < {9'd0, eff_lim}) ? diff_in[6:0] : eff_lim;
    assign n_start  = (cur_reg.xfer_len < {9'd0, eff_lim}) ? cur_reg.xfer_len[6:0] : eff_lim;

    always_comb
    begin
        rsp_next     = '0;
        ent_next     = rd;
        active_next  = active_reg;
        dflt_next    = dflt_reg;
        in_tog_next  = in_tog_reg;
        out_tog_next = out_tog_reg;
        ram_we       = 1'b0;

        if (state_reg == ST_EXEC)
        begin
            if (cur_reg.req_type == REQ_BUS_RESET)
            begin
                dflt_next            = 2'b11;
                active_next[1:0]     = 2'b00;
                in_tog_next          = 1'b1;
                out_tog_next         = 1'b1;
                rsp_next.ep_response = RSP_NACK;
                rsp_next.reset_seen  = 1'b1;
            end
            else if (in_range)
            begin
                ram_we = 1'b1;
                case (cur_reg.req_type)
                    REQ_OPEN:
                    begin
                        ent_next.limit = mp;
                        if (ep0)
                        begin
                            dflt_next[cur_dir] = 1'b0;
                        end
                        else
                        begin
                            rsp_next.ep_response = RSP_NACK;
                        end
                    end
                    REQ_START:
                    begin
                        active_next[slot_reg] = 1'b1;
                        ent_next.total        = cur_reg.xfer_len;
                        ent_next.done_bytes   = 16'd0;
                        ent_next.in_flight    = 7'd0;
                        if (cur_dir)
                        begin
                            ent_next.in_flight   = n_start;
                            rsp_next.ep_response = RSP_ACK;
                            rsp_next.load_len    = n_start;
                            rsp_next.copy_len    = n_start;
                            if (ep0)
                            begin
                                rsp_next.toggle_bit = in_tog_reg;
                            end
                        end
                        else if (ep0)
                        begin
                            if (cur_reg.xfer_len > {9'd0, eff_lim})
                            begin
                                rsp_next.error_code = ERR_EP0_OUT;
                            end
                            else
                            begin
                                rsp_next.ep_response = RSP_ACK;
                                rsp_next.toggle_bit  = out_tog_reg;
                            end
                        end
                        else
                        begin
                            rsp_next.ep_response = RSP_ACK;
                        end
                    end
                    default:
                    begin
                        if (cur_reg.token_kind == TOK_SETUP)
                        begin
                            in_tog_next         = 1'b1;
                            out_tog_next        = 1'b1;
                            rsp_next.setup_seen = 1'b1;
                        end
                        else if (cur_reg.token_kind == TOK_SOF)
                        begin
                            ram_we = 1'b0;
                        end
                        else if (!cur_reg.tog_ok)
                        begin
                            rsp_next.error_code = ERR_TOGGLE;
                        end
                        else if (cur_reg.token_kind == TOK_OUT)
                        begin
                            if (ep0 && rd.total == 16'd0)
                            begin
                                rsp_next.ep_response  = RSP_NACK;
                                rsp_next.toggle_bit   = out_tog_reg;
                                out_tog_next          = !out_tog_reg;
                                active_next[slot_reg] = 1'b0;
                                rsp_next.xfer_done    = 1'b1;
                                rsp_next.done_count   = rd.done_bytes;
                            end
                            else
                            begin
                                if (n_out != 7'd0)
                                begin
                                    rsp_next.copy_offset = rd.done_bytes;
                                    rsp_next.copy_len    = n_out;
                                    ent_next.done_bytes  = done_out;
                                end
                                if (ep0)
                                begin
                                    rsp_next.toggle_bit = out_tog_reg;
                                end
                                if ((ep0 && rx == eff_lim)
                                    || (!ep0 && rx >= eff_lim && done_out != rd.total))
                                begin
                                    rsp_next.ep_response = RSP_ACK;
                                end
                                else
                                begin
                                    rsp_next.ep_response  = RSP_NACK;
                                    active_next[slot_reg] = 1'b0;
                                    rsp_next.xfer_done    = 1'b1;
                                    rsp_next.done_count   = done_out;
                                end
                            end
                        end
                        else
                        begin
                            ent_next.done_bytes = done_in;
                            if (ep0)
                            begin
                                if (rd.total != 16'd0)
                                begin
                                    in_tog_next = !in_tog_reg;
                                end
                                if (rd.total == 16'd0 || done_in == rd.total)
                                begin
                                    rsp_next.ep_response  = RSP_NACK;
                                    rsp_next.toggle_bit   = in_tog_next;
                                    active_next[slot_reg] = 1'b0;
                                    rsp_next.xfer_done    = 1'b1;
                                    rsp_next.done_count   = done_in;
                                end
                                else
                                begin
                                    rsp_next.error_code = ERR_EP0_MULTI;
                                end
                            end
                            else if (rd.total > done_in)
                            begin
                                ent_next.in_flight   = n_in;
                                rsp_next.ep_response = RSP_ACK;
                                rsp_next.load_len    = n_in;
                                rsp_next.copy_offset = done_in;
                                rsp_next.copy_len    = n_in;
                            end
                            else
                            begin
                                ent_next.in_flight   = 7'd0;
                                rsp_next.ep_response = RSP_NACK;
                                rsp_next.xfer_done   = 1'b1;
                                rsp_next.done_count  = done_in;
                            end
                        end
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next     = ST_IDLE;
                rsp_valid_next = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            active_reg    <= '0;
            dflt_reg      <= 2'b11;
            in_tog_reg    <= 1'b1;
            out_tog_reg   <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            active_reg    <= active_next;
            dflt_reg      <= dflt_next;
            in_tog_reg    <= in_tog_next;
            out_tog_reg   <= out_tog_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_reg  <= req;
            slot_reg <= acc_addr;
        end
        if (state_reg == ST_EXEC)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_exec_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EXEC |=> rsp_valid)
        else $error("result not loaded after table update");

    a_bus_reset_ep0: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EXEC && cur_reg.req_type == REQ_BUS_RESET
        |=> !active_reg[0] && !active_reg[1] && in_tog_reg && out_tog_reg
            && dflt_reg == 2'b11)
        else $error("bus reset left endpoint 0 state behind");

    a_no_accept_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |-> req_stall)
        else $error("request accepted while result register blocked");

    a_count_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.xfer_done |-> rsp.done_count == 16'd0)
        else $error("done count without completion");

endmodule

// ===== hdl/uets_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module uets_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
